// ----- sv/modbus_read_reply_parser_defines.svh -----
// ----------------------------------------------------------------------------
// modbus read reply parser assertion macros
// shared property forms for the checks at the end of the rtl modules
// ----------------------------------------------------------------------------
`ifndef MODBUS_READ_REPLY_PARSER_DEFINES_SVH
`define MODBUS_READ_REPLY_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MRRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrrp same-cycle check failed");

// next-cycle implication, checked outside reset
`define MRRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrrp next-cycle check failed");

`endif

// ----- sv/mrrp_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrp_pkg
// types, codes and the crc byte update for the modbus read reply parser
// ----------------------------------------------------------------------------
`default_nettype none

package mrrp_pkg;

   // frame constants
   localparam logic [7:0]  FUNC_READ_HOLDING   = 8'h03;
   localparam logic [7:0]  BYTE_COUNT_ONE_WORD = 8'h02;
   localparam logic [7:0]  DEFAULT_MAX_ADDRESS = 8'h06;
   localparam logic [15:0] CRC_INIT            = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFLECTED  = 16'hA001;

   // parse phases, one-hot
   typedef enum logic [6:0] {
      PH_HUNT    = 7'b0000001,
      PH_FUNC    = 7'b0000010,
      PH_COUNT   = 7'b0000100,
      PH_DATA_HI = 7'b0001000,
      PH_DATA_LO = 7'b0010000,
      PH_CRC_LO  = 7'b0100000,
      PH_CRC_HI  = 7'b1000000
   } phase_type;

   // completed frame as handed from the parser to the result register
   typedef struct packed {
      logic        hit;
      logic [7:0]  slave_address;
      logic [15:0] reading;
      logic        crc_ok;
   } result_type;

   // modbus crc-16, one byte, lsb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_i,
                                            input logic [7:0]  byte_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, byte_i};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- sv/mrrp_req_if.sv -----
// ----------------------------------------------------------------------------
// mrrp_req_if
// received byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mrrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/mrrp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mrrp_rsp_if
// completed reply channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mrrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  slave_address;
   logic [15:0] reading;
   logic        crc_ok;

   modport source (output valid, output slave_address, output reading, output crc_ok,
                   input ready);
   modport sink   (input valid, input slave_address, input reading, input crc_ok,
                   output ready);
endinterface

`default_nettype wire

// ----- sv/mrrp_csr_if.sv -----
// ----------------------------------------------------------------------------
// mrrp_csr_if
// register write channel for the highest accepted slave address
// ----------------------------------------------------------------------------
`default_nettype none

interface mrrp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] max_slave_address;

   modport source (output valid, output max_slave_address, input ready);
   modport sink   (input valid, input max_slave_address, output ready);
endinterface

`default_nettype wire

// ----- sv/mrrp_parser.sv -----
// ----------------------------------------------------------------------------
// mrrp_parser
// frame state machine, running crc and held address/word for one byte a step
// ----------------------------------------------------------------------------
`default_nettype none
`include "modbus_read_reply_parser_defines.svh"

module mrrp_parser
   import mrrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   input  wire logic [7:0] max_address,
   output result_type      result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  word_hi_ff, word_hi_in;
   logic [7:0]  word_lo_ff, word_lo_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_first_ff, crc_first_in;
   logic [15:0] crc_next;
   logic        addr_match;

   // one crc byte update, restarted from the initial value on a new frame
   assign crc_next   = crc_feed((phase_ff == PH_HUNT) ? CRC_INIT : crc_ff, rx_byte);
   assign addr_match = (rx_byte != 8'h00) && (rx_byte <= max_address);

   // next phase and held values
   always_comb begin
      phase_in       = phase_ff;
      addr_in        = addr_ff;
      word_hi_in     = word_hi_ff;
      word_lo_in     = word_lo_ff;
      crc_in         = crc_ff;
      crc_first_in   = crc_first_ff;
      result.hit     = 1'b0;
      result.crc_ok  = ({rx_byte, crc_first_ff} == crc_ff);
      result.slave_address = addr_ff;
      result.reading = {word_hi_ff, word_lo_ff};
      unique case (phase_ff)
         PH_HUNT: begin
            if (addr_match) begin
               addr_in  = rx_byte;
               crc_in   = crc_next;
               phase_in = PH_FUNC;
            end
         end
         PH_FUNC: begin
            if (rx_byte == FUNC_READ_HOLDING) begin
               crc_in   = crc_next;
               phase_in = PH_COUNT;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_COUNT: begin
            if (rx_byte == BYTE_COUNT_ONE_WORD) begin
               crc_in   = crc_next;
               phase_in = PH_DATA_HI;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_DATA_HI: begin
            word_hi_in = rx_byte;
            crc_in     = crc_next;
            phase_in   = PH_DATA_LO;
         end
         PH_DATA_LO: begin
            word_lo_in = rx_byte;
            crc_in     = crc_next;
            phase_in   = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            crc_first_in = rx_byte;
            phase_in     = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            result.hit = 1'b1;
            phase_in   = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // state registers, advanced only when a byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         crc_ff   <= CRC_INIT;
      end else if (step) begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
      end
   end

   // held payload
   always_ff @(posedge clock) begin
      if (step) begin
         addr_ff      <= addr_in;
         word_hi_ff   <= word_hi_in;
         word_lo_ff   <= word_lo_in;
         crc_first_ff <= crc_first_in;
      end
   end

   // checks
   `MRRP_ASSERT_NOW(a_hit_only_last, clock, reset, result.hit, phase_ff == PH_CRC_HI)
   `MRRP_ASSERT_NEXT(a_back_to_hunt, clock, reset, step && (phase_ff == PH_CRC_HI),
                     phase_ff == PH_HUNT)
   `MRRP_ASSERT_NEXT(a_zero_no_start, clock, reset,
                     step && (phase_ff == PH_HUNT) && (rx_byte == 8'h00),
                     phase_ff == PH_HUNT)

endmodule

`default_nettype wire

// ----- sv/modbus_read_reply_parser.sv -----
// order: an accepted byte waits in the input register and is parsed when it is consumed;
//   a completed reply is loaded into the result register when its last crc byte is consumed
// throughput: one byte per cycle while rsp is not stalled, set by the single input and result registers
// reset: synchronous, active high; parser hunts for an address, crc is all ones,
//   max slave address returns to 6, both registers empty
// ----------------------------------------------------------------------------
// modbus_read_reply_parser
// hunts a byte stream for a modbus rtu read-holding-register reply and
// reports address, data word and crc check
// ----------------------------------------------------------------------------
`default_nettype none
`include "modbus_read_reply_parser_defines.svh"

module modbus_read_reply_parser
   import mrrp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mrrp_req_if.sink   req_if,
   mrrp_rsp_if.source rsp_if,
   mrrp_csr_if.sink   csr_if
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_addr_ff;
   logic [15:0] rsp_reading_ff;
   logic        rsp_crc_ok_ff;
   logic [7:0]  max_addr_ff;
   logic        consume;
   result_type  result;

   // configuration register
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_addr_ff <= DEFAULT_MAX_ADDRESS;
      end else if (csr_if.valid) begin
         max_addr_ff <= csr_if.max_slave_address;
      end
   end

   // input register: byte is consumed once the result register can take it
   assign consume      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   mrrp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (consume),
      .rx_byte     (in_byte_ff),
      .max_address (max_addr_ff),
      .result      (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (consume && result.hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && result.hit) begin
         rsp_addr_ff    <= result.slave_address;
         rsp_reading_ff <= result.reading;
         rsp_crc_ok_ff  <= result.crc_ok;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.slave_address = rsp_addr_ff;
   assign rsp_if.reading       = rsp_reading_ff;
   assign rsp_if.crc_ok        = rsp_crc_ok_ff;

   // checks
   `MRRP_ASSERT_NOW(a_stall_cause, clock, reset, !req_if.ready,
                    in_valid_ff && rsp_valid_ff && !rsp_if.ready)
   `MRRP_ASSERT_NEXT(a_hit_lands, clock, reset, consume && result.hit, rsp_valid_ff)
   `MRRP_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_if.ready,
                    !consume || !in_valid_ff)

endmodule

`default_nettype wire

// ----- tb/mrrp_reply_checker.sv -----
// ----------------------------------------------------------------------------
// mrrp_reply_checker
// watches the byte, reply and register channels of the modbus reply parser,
// predicts each completed reply and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module mrrp_reply_checker
   import mrrp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mrrp_req_if       req_if,
   mrrp_rsp_if       rsp_if,
   mrrp_csr_if       csr_if,
   output int        errors,
   output int        pending
);

   typedef struct packed {
      logic [7:0]  slave_address;
      logic [15:0] reading;
      logic        crc_ok;
   } reply_type;

   reply_type   replies_due[$];

   // predicted parser state
   logic [7:0]  addr_limit;
   phase_type   phase;
   logic [7:0]  frame_addr;
   logic [15:0] frame_word;
   logic [15:0] crc_acc;
   logic [7:0]  crc_lo_rx;

   // reflected crc-16, fed one data bit at a time
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         r = (r[0] ^ d[i]) ? ((r >> 1) ^ CRC_POLY_REFLECTED) : (r >> 1);
      end
      return r;
   endfunction

   // advance the predicted parser by one received byte
   task automatic predict_byte(input logic [7:0] b);
      reply_type reply;
      case (phase)
         PH_HUNT: begin
            if (b != 8'h00 && b <= addr_limit) begin
               frame_addr = b;
               crc_acc    = crc16_byte(CRC_INIT, b);
               phase      = PH_FUNC;
            end
         end
         PH_FUNC: begin
            if (b == FUNC_READ_HOLDING) begin
               crc_acc = crc16_byte(crc_acc, b);
               phase   = PH_COUNT;
            end else begin
               phase = PH_HUNT;
            end
         end
         PH_COUNT: begin
            if (b == BYTE_COUNT_ONE_WORD) begin
               crc_acc = crc16_byte(crc_acc, b);
               phase   = PH_DATA_HI;
            end else begin
               phase = PH_HUNT;
            end
         end
         PH_DATA_HI: begin
            frame_word = {b, 8'h00};
            crc_acc    = crc16_byte(crc_acc, b);
            phase      = PH_DATA_LO;
         end
         PH_DATA_LO: begin
            frame_word[7:0] = b;
            crc_acc         = crc16_byte(crc_acc, b);
            phase           = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            crc_lo_rx = b;
            phase     = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            reply.slave_address = frame_addr;
            reply.reading       = frame_word;
            reply.crc_ok        = ({b, crc_lo_rx} == crc_acc);
            replies_due.insert(replies_due.size(), reply);
            phase = PH_HUNT;
         end
         default: begin
            phase = PH_HUNT;
         end
      endcase
   endtask

   // compare one reply transaction with the oldest prediction
   task automatic check_reply();
      reply_type want;
      if (replies_due.size() == 0) begin
         $error("unexpected reply: slave_address %0d reading %04h crc_ok %0b",
                rsp_if.slave_address, rsp_if.reading, rsp_if.crc_ok);
         errors++;
      end else begin
         want = replies_due.pop_front();
         if (rsp_if.slave_address !== want.slave_address) begin
            $error("slave_address expected %0d actual %0d",
                   want.slave_address, rsp_if.slave_address);
            errors++;
         end
         if (rsp_if.reading !== want.reading) begin
            $error("reading expected %04h actual %04h", want.reading, rsp_if.reading);
            errors++;
         end
         if (rsp_if.crc_ok !== want.crc_ok) begin
            $error("crc_ok expected %0b actual %0b", want.crc_ok, rsp_if.crc_ok);
            errors++;
         end
      end
   endtask

   // sample all channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         addr_limit = DEFAULT_MAX_ADDRESS;
         phase      = PH_HUNT;
         frame_addr = 8'h00;
         frame_word = 16'h0000;
         crc_acc    = CRC_INIT;
         crc_lo_rx  = 8'h00;
         replies_due.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_reply();
         end
         if (csr_if.valid && csr_if.ready) begin
            addr_limit = csr_if.max_slave_address;
         end
         if (req_if.valid && req_if.ready) begin
            predict_byte(req_if.rx_byte);
         end
      end
      pending = replies_due.size();
   end

endmodule

`default_nettype wire

// ----- tb/tb_modbus_read_reply_parser.sv -----
// ----------------------------------------------------------------------------
// tb_modbus_read_reply_parser
// drives byte streams of good, corrupted and broken modbus replies through
// the parser under several address limits with random stalls on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modbus_read_reply_parser;
   import mrrp_pkg::*;

   localparam int IDLE_LIMIT        = 2000;
   localparam int ITEMS_PER_SETTING = 250;
   localparam int DRAIN_CYCLES      = 4;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   logic hold_rsp;
   int   quiet_left;
   int   items_sent;

   mrrp_req_if req_if();
   mrrp_rsp_if rsp_if();
   mrrp_csr_if csr_if();

   modbus_read_reply_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   mrrp_reply_checker i_checker (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .csr_if  (csr_if),
      .errors  (errors),
      .pending (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // crc of the five frame bytes, for building replies
   function automatic logic [15:0] frame_crc(input logic [7:0] addr, input logic [15:0] word);
      logic [7:0]  body [5];
      logic [15:0] crc;
      body = '{addr, FUNC_READ_HOLDING, BYTE_COUNT_ONE_WORD, word[15:8], word[7:0]};
      crc  = CRC_INIT;
      foreach (body[k]) begin
         crc ^= {8'h00, body[k]};
         repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_REFLECTED) : (crc >> 1);
      end
      return crc;
   endfunction

   // one byte transaction, valid left high for a possible next byte
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else begin
         gap = gap_length();
         if ($urandom_range(0, 63) == 0) quiet_left = $urandom_range(20, 80);
      end
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.rx_byte = b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // send the first keep bytes of a reply; spoil overwrites one header byte
   task automatic send_frame(input logic [7:0] addr, input logic [15:0] word,
                             input bit bad_crc, input int keep, input int spoil);
      logic [7:0]  frame [7];
      logic [15:0] crc;
      crc = frame_crc(addr, word);
      if (bad_crc) crc ^= 16'($urandom_range(1, 65535));
      frame = '{addr, FUNC_READ_HOLDING, BYTE_COUNT_ONE_WORD, word[15:8], word[7:0],
                crc[7:0], crc[15:8]};
      if (spoil > 0) frame[spoil] = 8'($urandom_range(0, 255));
      for (int k = 0; k < keep; k++) push_byte(frame[k]);
   endtask

   // let every pending reply come out before touching the register
   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_addr_limit(input logic [7:0] value);
      wait_idle();
      csr_if.valid             = 1'b1;
      csr_if.max_slave_address = value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // random mix of well-formed replies, broken ones and line noise
   task automatic random_traffic(input logic [7:0] limit, input int count);
      int          r;
      int          target;
      logic [7:0]  addr;
      logic [15:0] word;
      target = items_sent + count;
      while (items_sent < target) begin
         r    = $urandom_range(0, 99);
         addr = (limit != 8'h00) ? 8'($urandom_range(1, limit)) : 8'($urandom_range(0, 255));
         word = 16'($urandom_range(0, 65535));
         if (r < 70) begin
            send_frame(addr, word, $urandom_range(0, 4) == 0, 7, 0);
         end else if (r < 80) begin
            send_frame(addr, word, 1'b0, $urandom_range(1, 6), 0);
         end else if (r < 87) begin
            send_frame(addr, word, 1'b0, 7, $urandom_range(1, 2));
         end else begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // reply side: ready runs, random stalls and one long hold-off on request
   initial begin : rsp_sink
      int run;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         run          = $urandom_range(1, 30);
         rsp_if.ready = 1'b1;
         repeat (run) @(negedge clock);
         run = gap_length();
         if (run > 0) begin
            rsp_if.ready = 1'b0;
            repeat (run) @(negedge clock);
         end
      end
   end

   // watchdog: ends the run when no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[modbus_read_reply_parser] ERROR");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      logic [7:0] limits [6];
      reset                    = 1'b1;
      hold_rsp                 = 1'b0;
      quiet_left               = 0;
      items_sent               = 0;
      req_if.valid             = 1'b0;
      req_if.rx_byte           = 8'h00;
      csr_if.valid             = 1'b0;
      csr_if.max_slave_address = 8'h00;
      limits = '{8'd1, 8'd247, 8'd0, 8'd255, 8'($urandom_range(1, 247)),
                 8'($urandom_range(0, 255))};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part under the reset limit of 6
      push_byte(8'h00);                       // broadcast address never starts a frame
      push_byte(8'h07);                       // just above the limit
      send_frame(8'h01, 16'h0000, 1'b0, 7, 0);
      send_frame(8'h06, 16'hFFFF, 1'b0, 7, 0);
      send_frame(8'h03, 16'hA55A, 1'b1, 7, 0); // crc failure still reported
      push_byte(8'h05);                       // wrong function code, itself an address
      push_byte(8'h04);
      push_byte(8'h05);                       // wrong byte count, itself an address
      push_byte(FUNC_READ_HOLDING);
      push_byte(8'h05);
      send_frame(8'h02, 16'h8001, 1'b0, 7, 0);

      // random part under a series of address limits
      foreach (limits[s]) begin
         write_addr_limit(limits[s]);
         if (s == 0) hold_rsp = 1'b1;
         random_traffic(limits[s], ITEMS_PER_SETTING);
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("[modbus_read_reply_parser] OK");
      end else begin
         $display("[modbus_read_reply_parser] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
